### rtl/core/http_header_line_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP header line parser
// Shared concurrent checks on clk with the active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_PARSER_MACROS_SVH
`define HTTP_HEADER_LINE_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define HHLP_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hhlp same-cycle check failed");

// Check that a condition implies another in the next cycle
`define HHLP_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hhlp next-cycle check failed");

`endif

### rtl/core/hhlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types and constants of the HTTP header line parser.
// ----------------------------------------------------------------------------
package hhlp_pkg;

    // Characters that steer the parse
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Parse phases
    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_KEY    = 3'd1;
    localparam logic [2:0] PH_SPACES = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // Result kinds
    localparam logic [2:0] K_KEY     = 3'd0;
    localparam logic [2:0] K_VALUE   = 3'd1;
    localparam logic [2:0] K_PAIR    = 3'd2;
    localparam logic [2:0] K_DISCARD = 3'd3;
    localparam logic [2:0] K_END     = 3'd4;

    // Most results one input byte can cause
    localparam int MAX_BEATS = 4;

    // One result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } beat_t;

    // Outcome of one parse step on the line state
    typedef struct packed {
        logic [2:0] phase;
        logic       lhc;
        logic       emit;
        beat_t      beat;
    } step_t;

endpackage
`default_nettype wire

### rtl/core/hhlp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhlp_if
// Valid/ready channels of the HTTP header line parser: raw bytes in,
// header field beats out.
// ----------------------------------------------------------------------------
interface hhlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface hhlp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output kind, output out_byte, output run_last,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input run_last,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/http_header_line_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_header_line_parser
// Splits a raw HTTP header block into lowercased key bytes, value bytes and
// pair / discard / end markers.
// ----------------------------------------------------------------------------
// Usage:
//   hdr_in carries one header byte per beat, with last on the final byte of
//   the block. fld_out carries result beats (kind, out_byte, run_last);
//   run_last marks the final beat caused by one input byte.
//   A byte is parsed in the cycle it is accepted; its results (zero to four)
//   sit in a four-entry batch register and leave one per cycle from the
//   next cycle on while the receiver is ready.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver is ready. A byte that gives more than one result holds
//   the input until its batch is down to its last beat, since the single
//   output port drains the batch one beat a cycle while the receiver is ready.
//   Bytes that give no result (status line, spaces after the colon, a CR
//   whose meaning is still open) pass at one per cycle while the batch is empty.
//   Reset clears the parse state to status line skipping and empties the
//   batch. When the receiver stalls, the current beat holds and the input
//   stops once the batch is down to its last beat.
// ----------------------------------------------------------------------------
`include "http_header_line_parser_macros.svh"

module http_header_line_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hhlp_in_if.sink     hdr_in,
    hhlp_out_if.source  fld_out
);

    localparam int CntW = $clog2(hhlp_pkg::MAX_BEATS + 1);
    localparam int IdxW = $clog2(hhlp_pkg::MAX_BEATS);

    // Parse state
    logic [2:0] phase_reg, phase_next;
    logic       cr_reg, cr_next;
    logic       lhc_reg, lhc_next;

    // Result batch
    hhlp_pkg::beat_t [hhlp_pkg::MAX_BEATS-1:0] batch_reg, batch_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    // Step results of this byte
    hhlp_pkg::beat_t [hhlp_pkg::MAX_BEATS-1:0] new_beats;
    logic [CntW-1:0] n_res;

    logic acc, pop;

    // Content byte: lowercase keys, split at colon, skip leading spaces
    function automatic hhlp_pkg::step_t content_step(logic [2:0] ph, logic lhc,
                                                     logic [7:0] b);
        hhlp_pkg::step_t s;
        s.phase = ph;
        s.lhc   = lhc;
        s.emit  = 1'b0;
        s.beat  = '0;
        case (ph)
            hhlp_pkg::PH_KEY:
            begin
                s.lhc = 1'b1;
                if (b == hhlp_pkg::CH_COLON)
                begin
                    s.phase = hhlp_pkg::PH_SPACES;
                end
                else
                begin
                    s.emit      = 1'b1;
                    s.beat.kind = hhlp_pkg::K_KEY;
                    s.beat.data = (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
                end
            end
            hhlp_pkg::PH_SPACES:
            begin
                if (b != hhlp_pkg::CH_SPACE)
                begin
                    s.phase     = hhlp_pkg::PH_VALUE;
                    s.emit      = 1'b1;
                    s.beat.kind = hhlp_pkg::K_VALUE;
                    s.beat.data = b;
                end
            end
            hhlp_pkg::PH_VALUE:
            begin
                s.emit      = 1'b1;
                s.beat.kind = hhlp_pkg::K_VALUE;
                s.beat.data = b;
            end
            default:
            begin
                s.emit = 1'b0;
            end
        endcase
        return s;
    endfunction

    // Line end: pair, discard, or end of headers on an empty line
    function automatic hhlp_pkg::step_t line_end_step(logic [2:0] ph, logic lhc);
        hhlp_pkg::step_t s;
        s.emit      = 1'b1;
        s.lhc       = 1'b0;
        s.beat.data = '0;
        s.phase     = hhlp_pkg::PH_KEY;
        if (ph == hhlp_pkg::PH_KEY)
        begin
            if (lhc)
            begin
                s.beat.kind = hhlp_pkg::K_DISCARD;
            end
            else
            begin
                s.beat.kind = hhlp_pkg::K_END;
                s.phase     = hhlp_pkg::PH_DONE;
            end
        end
        else
        begin
            s.beat.kind = hhlp_pkg::K_PAIR;
        end
        return s;
    endfunction

    // Parse one byte into up to four beats
    always_comb
    begin
        logic [2:0]      ph;
        logic            cr;
        logic            lhc;
        logic            ended;
        logic            in_line;
        logic [CntW-1:0] n;
        logic [7:0]      b;
        hhlp_pkg::step_t s;

        ph    = phase_reg;
        cr    = cr_reg;
        lhc   = lhc_reg;
        ended = 1'b0;
        n     = '0;
        b     = hdr_in.data_byte;
        s     = '0;
        new_beats = '0;
        in_line = (ph == hhlp_pkg::PH_KEY) || (ph == hhlp_pkg::PH_SPACES)
               || (ph == hhlp_pkg::PH_VALUE);

        if (ph == hhlp_pkg::PH_SKIP)
        begin
            if (cr && b == hhlp_pkg::CH_LF)
            begin
                ph  = hhlp_pkg::PH_KEY;
                cr  = 1'b0;
                lhc = 1'b0;
            end
            else
            begin
                cr = (b == hhlp_pkg::CH_CR);
            end
        end
        else if (in_line)
        begin
            // Resolve a pending CR
            if (cr)
            begin
                cr = 1'b0;
                if (b == hhlp_pkg::CH_LF)
                begin
                    s     = line_end_step(ph, lhc);
                    ended = 1'b1;
                end
                else
                begin
                    s = content_step(ph, lhc, hhlp_pkg::CH_CR);
                end
                ph  = s.phase;
                lhc = s.lhc;
                if (s.emit && n < CntW'(hhlp_pkg::MAX_BEATS))
                begin
                    new_beats[n[IdxW-1:0]] = s.beat;
                    n = n + 1'b1;
                end
            end
            // Handle the byte itself
            if (!ended)
            begin
                if (b == hhlp_pkg::CH_CR)
                begin
                    cr = 1'b1;
                end
                else
                begin
                    s   = content_step(ph, lhc, b);
                    ph  = s.phase;
                    lhc = s.lhc;
                    if (s.emit && n < CntW'(hhlp_pkg::MAX_BEATS))
                    begin
                        new_beats[n[IdxW-1:0]] = s.beat;
                        n = n + 1'b1;
                    end
                end
            end
        end

        // Close the block on the final byte
        if (hdr_in.last)
        begin
            in_line = (ph == hhlp_pkg::PH_KEY) || (ph == hhlp_pkg::PH_SPACES)
                   || (ph == hhlp_pkg::PH_VALUE);
            if (ph == hhlp_pkg::PH_SKIP)
            begin
                if (n < CntW'(hhlp_pkg::MAX_BEATS))
                begin
                    new_beats[n[IdxW-1:0]] = '{kind: hhlp_pkg::K_END, data: 8'h00};
                    n = n + 1'b1;
                end
            end
            else if (in_line)
            begin
                if (cr)
                begin
                    s   = content_step(ph, lhc, hhlp_pkg::CH_CR);
                    ph  = s.phase;
                    lhc = s.lhc;
                    if (s.emit && n < CntW'(hhlp_pkg::MAX_BEATS))
                    begin
                        new_beats[n[IdxW-1:0]] = s.beat;
                        n = n + 1'b1;
                    end
                end
                if ((ph != hhlp_pkg::PH_KEY || lhc) && n < CntW'(hhlp_pkg::MAX_BEATS))
                begin
                    new_beats[n[IdxW-1:0]] = '{kind: hhlp_pkg::K_DISCARD, data: 8'h00};
                    n = n + 1'b1;
                end
                if (n < CntW'(hhlp_pkg::MAX_BEATS))
                begin
                    new_beats[n[IdxW-1:0]] = '{kind: hhlp_pkg::K_END, data: 8'h00};
                    n = n + 1'b1;
                end
            end
            ph  = hhlp_pkg::PH_SKIP;
            cr  = 1'b0;
            lhc = 1'b0;
        end

        phase_next = ph;
        cr_next    = cr;
        lhc_next   = lhc;
        n_res      = n;
    end

    // Handshakes: take a byte when the batch is empty or draining its last beat
    assign pop            = fld_out.valid && fld_out.ready;
    assign hdr_in.ready   = (cnt_reg == '0) || (cnt_reg == CntW'(1) && fld_out.ready);
    assign acc            = hdr_in.valid && hdr_in.ready;

    // Load a new batch or advance the current one
    always_comb
    begin
        batch_next = batch_reg;
        cnt_next   = cnt_reg;
        if (acc)
        begin
            batch_next = new_beats;
            cnt_next   = n_res;
        end
        else if (pop)
        begin
            for (int i = 0; i < hhlp_pkg::MAX_BEATS - 1; i++)
            begin
                batch_next[i] = batch_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hhlp_pkg::PH_SKIP;
            cr_reg    <= 1'b0;
            lhc_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg <= phase_next;
                cr_reg    <= cr_next;
                lhc_reg   <= lhc_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Batch payload
    always_ff @(posedge clk)
    begin
        batch_reg <= batch_next;
    end

    // Drive the output beat
    assign fld_out.valid    = (cnt_reg != '0);
    assign fld_out.kind     = batch_reg[0].kind;
    assign fld_out.out_byte = batch_reg[0].data;
    assign fld_out.run_last = (cnt_reg == CntW'(1));

    // Checks
    `HHLP_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CntW'(hhlp_pkg::MAX_BEATS))
    `HHLP_ASSERT_NEXT(a_results_shown, acc && n_res != '0, fld_out.valid)
    `HHLP_ASSERT_NEXT(a_drained, pop && cnt_reg == CntW'(1) && !acc, !fld_out.valid)
    `HHLP_ASSERT_NEXT(a_last_resets, acc && hdr_in.last,
                      phase_reg == hhlp_pkg::PH_SKIP && !cr_reg && !lhc_reg)

endmodule
`default_nettype wire

### tb/http_header_line_parser_test.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_test
// Self-checking bench for the HTTP header line parser. Header blocks are fed
// one byte per beat and every result beat is compared with the beat that a
// behavioral copy of the parser expects. Short handmade blocks come first,
// then random blocks, mostly well formed with random content. Both channels
// idle at random, and the bench also applies one long output stall and
// drains fully after each random run.
// ----------------------------------------------------------------------------
module http_header_line_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       run_last;
    } field_beat_t;

    // Behavioral copy of the parser plus the queue of beats still owed
    class hdr_field_scoreboard;
        field_beat_t     pending_beats[$];
        hhlp_pkg::beat_t step_beats[hhlp_pkg::MAX_BEATS];
        int              step_count;
        logic [2:0]      phase;
        logic            cr_pending;
        logic            line_has_content;
        int              errors;
        int              beats_checked;
        int              pairs_seen;
        int              discards_seen;
        int              ends_seen;

        function new();
            clear_parse();
            errors        = 0;
            beats_checked = 0;
            pairs_seen    = 0;
            discards_seen = 0;
            ends_seen     = 0;
        endfunction

        function void clear_parse();
            phase            = hhlp_pkg::PH_SKIP;
            cr_pending       = 1'b0;
            line_has_content = 1'b0;
        endfunction

        // Add one beat to the current byte's batch, capped at the batch size
        function void emit(input logic [2:0] kind, input logic [7:0] data);
            if (step_count < hhlp_pkg::MAX_BEATS)
            begin
                step_beats[step_count].kind = kind;
                step_beats[step_count].data = data;
                step_count++;
            end
        endfunction

        // Place one content byte into the key or value of the current line
        function void take_content(input logic [7:0] b);
            case (phase)
                hhlp_pkg::PH_KEY:
                begin
                    line_has_content = 1'b1;
                    if (b == hhlp_pkg::CH_COLON)
                        phase = hhlp_pkg::PH_SPACES;
                    else
                        emit(hhlp_pkg::K_KEY, (b >= "A" && b <= "Z") ? b + 8'h20 : b);
                end
                hhlp_pkg::PH_SPACES:
                begin
                    if (b != hhlp_pkg::CH_SPACE)
                    begin
                        phase = hhlp_pkg::PH_VALUE;
                        emit(hhlp_pkg::K_VALUE, b);
                    end
                end
                hhlp_pkg::PH_VALUE:
                    emit(hhlp_pkg::K_VALUE, b);
                default:
                    ;
            endcase
        endfunction

        // Close a line on CR LF: pair, discard, or end of headers when empty
        function void close_line();
            if (phase == hhlp_pkg::PH_KEY)
            begin
                if (line_has_content)
                    emit(hhlp_pkg::K_DISCARD, 8'h00);
                else
                begin
                    emit(hhlp_pkg::K_END, 8'h00);
                    phase = hhlp_pkg::PH_DONE;
                end
            end
            else
                emit(hhlp_pkg::K_PAIR, 8'h00);
            if (phase != hhlp_pkg::PH_DONE)
                phase = hhlp_pkg::PH_KEY;
            line_has_content = 1'b0;
        endfunction

        // Advance the parse by one accepted input beat and queue its results
        function void note_input(input logic [7:0] b, input logic fin);
            bit          ended;
            field_beat_t exp_beat;

            step_count = 0;
            ended      = 0;
            if (phase == hhlp_pkg::PH_SKIP)
            begin
                if (cr_pending && b == hhlp_pkg::CH_LF)
                begin
                    phase            = hhlp_pkg::PH_KEY;
                    cr_pending       = 1'b0;
                    line_has_content = 1'b0;
                end
                else
                    cr_pending = (b == hhlp_pkg::CH_CR);
            end
            else if (phase >= hhlp_pkg::PH_KEY && phase <= hhlp_pkg::PH_VALUE)
            begin
                // Resolve a held CR: line end on LF, plain content otherwise
                if (cr_pending)
                begin
                    cr_pending = 1'b0;
                    if (b == hhlp_pkg::CH_LF)
                    begin
                        close_line();
                        ended = 1;
                    end
                    else
                        take_content(hhlp_pkg::CH_CR);
                end
                if (!ended)
                begin
                    if (b == hhlp_pkg::CH_CR)
                        cr_pending = 1'b1;
                    else
                        take_content(b);
                end
            end

            // Flush the block on its final byte
            if (fin)
            begin
                if (phase == hhlp_pkg::PH_SKIP)
                    emit(hhlp_pkg::K_END, 8'h00);
                else if (phase >= hhlp_pkg::PH_KEY && phase <= hhlp_pkg::PH_VALUE)
                begin
                    if (cr_pending)
                    begin
                        cr_pending = 1'b0;
                        take_content(hhlp_pkg::CH_CR);
                    end
                    if (phase != hhlp_pkg::PH_KEY || line_has_content)
                        emit(hhlp_pkg::K_DISCARD, 8'h00);
                    emit(hhlp_pkg::K_END, 8'h00);
                end
                clear_parse();
            end

            for (int i = 0; i < step_count; i++)
            begin
                exp_beat.kind     = step_beats[i].kind;
                exp_beat.data     = step_beats[i].data;
                exp_beat.run_last = (i == step_count - 1);
                pending_beats     = {pending_beats, exp_beat};
            end
        endfunction

        // Compare one accepted output beat with the oldest expected beat
        function void check_beat(input logic [2:0] kind, input logic [7:0] data,
                                 input logic run_last);
            field_beat_t exp_beat;

            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d out_byte 0x%02h run_last %0d",
                       kind, data, run_last);
                errors++;
                return;
            end
            exp_beat = pending_beats.pop_front();
            beats_checked++;
            if (kind !== exp_beat.kind)
            begin
                $error("kind: expected %0d, got %0d", exp_beat.kind, kind);
                errors++;
            end
            if (data !== exp_beat.data)
            begin
                $error("out_byte: expected 0x%02h, got 0x%02h", exp_beat.data, data);
                errors++;
            end
            if (run_last !== exp_beat.run_last)
            begin
                $error("run_last: expected %0d, got %0d", exp_beat.run_last, run_last);
                errors++;
            end
            case (exp_beat.kind)
                hhlp_pkg::K_PAIR:    pairs_seen++;
                hhlp_pkg::K_DISCARD: discards_seen++;
                hhlp_pkg::K_END:     ends_seen++;
                default:             ;
            endcase
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hhlp_in_if  hdr_in();
    hhlp_out_if fld_out();

    http_header_line_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr_in  (hdr_in),
        .fld_out (fld_out)
    );

    hdr_field_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int bytes_sent;
    int blocks_sent;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a header-like character, now and then any byte at all
    function automatic logic [7:0] pick_text();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'("a" + $urandom_range(25));
            4, 5:       return 8'("A" + $urandom_range(25));
            6:          return 8'("0" + $urandom_range(9));
            7:          return "-";
            8:          return hhlp_pkg::CH_SPACE;
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    // Build one random header block, mostly well formed
    function automatic byte_q_t make_block();
        byte_q_t blk;
        int      cut;

        blk = {};
        repeat ($urandom_range(6)) blk = {blk, pick_text()};
        blk = {blk, hhlp_pkg::CH_CR};
        blk = {blk, hhlp_pkg::CH_LF};

        // Noise: bytes dense in the characters that steer the parse
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(4))
                    0:       blk = {blk, hhlp_pkg::CH_CR};
                    1:       blk = {blk, hhlp_pkg::CH_LF};
                    2:       blk = {blk, hhlp_pkg::CH_COLON};
                    3:       blk = {blk, hhlp_pkg::CH_SPACE};
                    default: blk = {blk, 8'($urandom_range(255))};
                endcase
            end
            return blk;
        end

        repeat ($urandom_range(4))
        begin
            if ($urandom_range(19) == 0)
            begin
                // Line with no colon
                repeat ($urandom_range(1, 4)) blk = {blk, pick_text()};
            end
            else
            begin
                repeat ($urandom_range(5)) blk = {blk, pick_text()};
                blk = {blk, hhlp_pkg::CH_COLON};
                repeat ($urandom_range(2)) blk = {blk, hhlp_pkg::CH_SPACE};
                repeat ($urandom_range(6))
                begin
                    case ($urandom_range(11))
                        0:       blk = {blk, hhlp_pkg::CH_CR};
                        1:       blk = {blk, hhlp_pkg::CH_LF};
                        default: blk = {blk, pick_text()};
                    endcase
                end
            end
            blk = {blk, hhlp_pkg::CH_CR};
            blk = {blk, hhlp_pkg::CH_LF};
        end
        blk = {blk, hhlp_pkg::CH_CR};
        blk = {blk, hhlp_pkg::CH_LF};

        // Trailing bytes after the headers end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) blk = {blk, 8'($urandom_range(255))};

        // Truncate now and then so the final byte lands mid-line
        if ($urandom_range(7) == 0)
        begin
            cut = $urandom_range(blk.size() - 2);
            blk = blk[0:cut];
        end
        return blk;
    endfunction

    // Offer one byte and hold it until the parser takes the beat
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hdr_in.valid <= 1'b0;
            @(posedge clk);
        end
        hdr_in.valid     <= 1'b1;
        hdr_in.data_byte <= b;
        hdr_in.last      <= fin;
        @(posedge clk);
        while (!hdr_in.ready) @(posedge clk);
        sb.note_input(b, fin);
        bytes_sent++;
    endtask

    task automatic send_block(input byte_q_t blk);
        foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
        blocks_sent++;
    endtask

    task automatic send_random(input int upto);
        byte_q_t blk;

        while (bytes_sent < upto)
        begin
            blk = make_block();
            send_block(blk);
        end
    endtask

    // Stop offering and wait until every expected beat has come out
    task automatic drain();
        hdr_in.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_beats.size() != 0) @(posedge clk);
    endtask

    // Output side: check each accepted beat, drive ready with random stalls
    initial
    begin
        int hold_seen;
        int hold_left;

        hold_seen     = 0;
        hold_left     = 0;
        fld_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (fld_out.valid && fld_out.ready)
                sb.check_beat(fld_out.kind, fld_out.out_byte, fld_out.run_last);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                fld_out.ready <= 1'b0;
                hold_left--;
            end
            else
                fld_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when neither side moves a beat for too long
    initial
    begin
        int quiet;

        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((hdr_in.valid && hdr_in.ready) || (fld_out.valid && fld_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL http_header_line_parser");
        $finish;
    end

    // Stimulus
    initial
    begin
        sb               = new();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_req         = 0;
        bytes_sent       = 0;
        blocks_sent      = 0;
        rst_n            = 1'b0;
        hdr_in.valid     = 1'b0;
        hdr_in.data_byte = 8'h00;
        hdr_in.last      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty status line, key case folding at the A/Z bounds,
        // dropped spaces, lone CR and bare LF in a value, empty key and
        // value, a line without a colon, end of headers, ignored trailers
        send_block('{hhlp_pkg::CH_CR, hhlp_pkg::CH_LF, "A", "Z", "@", "[",
                     hhlp_pkg::CH_COLON, hhlp_pkg::CH_SPACE, hhlp_pkg::CH_SPACE,
                     hhlp_pkg::CH_CR, "x", hhlp_pkg::CH_LF,
                     hhlp_pkg::CH_CR, hhlp_pkg::CH_LF,
                     hhlp_pkg::CH_COLON, hhlp_pkg::CH_CR, hhlp_pkg::CH_LF,
                     "q", hhlp_pkg::CH_CR, hhlp_pkg::CH_LF,
                     hhlp_pkg::CH_CR, hhlp_pkg::CH_LF, 8'hFF, 8'h00});
        // Status line never ended, final byte is a CR
        send_block('{hhlp_pkg::CH_CR});
        // Unterminated key with a CR held at the final byte
        send_block('{hhlp_pkg::CH_CR, hhlp_pkg::CH_LF, "k", hhlp_pkg::CH_CR});
        // Final byte is the colon, line still open
        send_block('{hhlp_pkg::CH_CR, hhlp_pkg::CH_LF, hhlp_pkg::CH_COLON});

        // Sender busy with gaps, receiver stalling a lot
        send_idle_pct = 30;
        recv_idle_pct = 71;
        send_random(bytes_sent + 75);
        drain();

        // Sender sparse, receiver mostly ready
        send_idle_pct = 71;
        recv_idle_pct = 30;
        send_random(bytes_sent + 75);
        drain();

        // No idling; hold the receiver off while bytes keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= hold_req + 1;
        send_random(bytes_sent + 70);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d header bytes in %0d blocks; %0d result beats matched.",
                 bytes_sent, blocks_sent, sb.beats_checked);
        $display("Markers: %0d pairs, %0d discarded lines, %0d header ends.",
                 sb.pairs_seen, sb.discards_seen, sb.ends_seen);
        if (sb.errors == 0)
            $display("PASS http_header_line_parser");
        else
            $display("FAIL http_header_line_parser");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hhlp_pkg.sv
rtl/core/hhlp_if.sv
rtl/core/http_header_line_parser.sv
tb/http_header_line_parser_test.sv
